### sv/arsc_pkg.sv
// Shared types and constants for the audio RMS snore classifier.
package arsc_pkg;

  localparam int LVL_W      = 16;
  localparam int ENV_W      = 16;
  localparam int CNT_W      = 10;
  localparam int SCORE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // operation codes
  localparam logic OP_AUDIO   = 1'b0;
  localparam logic OP_FEATURE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SNORE_THRESHOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPLASH_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_THRESHOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_THRESHOLD = 3'd5;

  // register reset values
  localparam logic [CNT_W-1:0] RST_UPDATE_INTERVAL    = 10'd100;
  localparam logic [LVL_W-1:0] RST_SNORE_THRESHOLD    = 16'd150;
  localparam logic [LVL_W-1:0] RST_SIGNAL_THRESHOLD   = 16'd50;
  localparam logic [LVL_W-1:0] RST_SPLASH_THRESHOLD   = 16'd50;
  localparam logic [LVL_W-1:0] RST_BAND_THRESHOLD     = 16'd100;
  localparam logic [LVL_W-1:0] RST_ENVELOPE_THRESHOLD = 16'd100;

  // stored feature reset values
  localparam logic [LVL_W-1:0] RST_SNORE    = 16'd142;
  localparam logic [LVL_W-1:0] RST_BREATH   = 16'd95;
  localparam logic [LVL_W-1:0] RST_SIGNAL   = 16'd0;
  localparam logic [LVL_W-1:0] RST_SPLASH   = 16'd0;
  localparam logic [LVL_W-1:0] RST_BAND     = 16'd10;
  localparam logic [ENV_W-1:0] RST_ENVELOPE = 16'd50;

  // score weights in tenths
  localparam logic [SCORE_W-1:0] W_SNORE    = 4'd3;
  localparam logic [SCORE_W-1:0] W_SIGNAL   = 4'd2;
  localparam logic [SCORE_W-1:0] W_SPLASH   = 4'd2;
  localparam logic [SCORE_W-1:0] W_BAND     = 4'd2;
  localparam logic [SCORE_W-1:0] W_ENVELOPE = 4'd1;
  localparam logic [SCORE_W-1:0] W_RATIO    = 4'd2;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 4'd10;
  localparam logic [SCORE_W-1:0] SNORE_MIN  = 4'd5;

  typedef struct packed {
    logic accept;     // latch request, read ring at write position
    logic ring_upd;   // write ring, square old and new samples
    logic sum_upd;    // update square sum and interval counter
    logic root_load;  // start square root on window mean
    logic root_step;  // one root bit
    logic emit;       // load output register
  } arsc_cmd_t;

  typedef struct packed {
    logic hit;        // interval reached on this sample
    logic root_last;  // final root bit in this step
    logic slot_free;  // output register can take a result
  } arsc_sts_t;

endpackage

### sv/arsc_ctrl.sv
// Sequencing state machine for the snore classifier.
module arsc_ctrl import arsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_operation,
  input  arsc_sts_t sts,
  output arsc_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_SUM  = 6'b000100,
    S_LOAD = 6'b001000,
    S_ROOT = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_operation == OP_FEATURE) ? S_EMIT : S_READ;
        end
      end
      S_READ: begin
        cmd.ring_upd = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.sum_upd = 1'b1;
        state_nxt   = sts.hit ? S_LOAD : S_IDLE;
      end
      S_LOAD: begin
        cmd.root_load = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### sv/arsc_dp.sv
// Datapath: sample ring, square sum, square root, scoring and output register.
module arsc_dp import arsc_pkg::*; #(
  parameter int WINDOW_DEPTH = 8192,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  arsc_cmd_t                     cmd,
  output arsc_sts_t                     sts,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_operation,
  input  logic signed [SAMPLE_BITS-1:0] in_audio_sample,
  input  logic [LVL_W-1:0]              in_snore_level,
  input  logic [LVL_W-1:0]              in_breath_level,
  input  logic [LVL_W-1:0]              in_signal_level,
  input  logic [LVL_W-1:0]              in_splash_level,
  input  logic [LVL_W-1:0]              in_band_level,
  input  logic [LVL_W-1:0]              in_envelope_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_snoring,
  output logic [SCORE_W-1:0]            out_snore_probability,
  output logic [SCORE_W-1:0]            out_confidence,
  output logic [ENV_W-1:0]              out_envelope
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W = SQ_W + AW;
  localparam int V_W   = 2 * SAMPLE_BITS;
  localparam int REM_W = SAMPLE_BITS + 2;
  localparam int IT_W  = $clog2(SAMPLE_BITS);

  // configuration registers
  logic [CNT_W-1:0] interval_r;
  logic [LVL_W-1:0] thr_snore_r, thr_signal_r, thr_splash_r, thr_band_r, thr_env_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= RST_UPDATE_INTERVAL;
      thr_snore_r  <= RST_SNORE_THRESHOLD;
      thr_signal_r <= RST_SIGNAL_THRESHOLD;
      thr_splash_r <= RST_SPLASH_THRESHOLD;
      thr_band_r   <= RST_BAND_THRESHOLD;
      thr_env_r    <= RST_ENVELOPE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPDATE_INTERVAL:    interval_r   <= cfg_data[CNT_W-1:0];
        REG_SNORE_THRESHOLD:    thr_snore_r  <= cfg_data;
        REG_SIGNAL_THRESHOLD:   thr_signal_r <= cfg_data;
        REG_SPLASH_THRESHOLD:   thr_splash_r <= cfg_data;
        REG_BAND_THRESHOLD:     thr_band_r   <= cfg_data;
        REG_ENVELOPE_THRESHOLD: thr_env_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample ring; an entry reads as zero until the first full pass has written it
  logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic [AW-1:0]                 pos_r;
  logic                          wrapped_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data_r <= ring_mem[pos_r];
    end
    if (cmd.ring_upd) begin
      ring_mem[pos_r] <= samp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      samp_r <= in_audio_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
    end else if (cmd.ring_upd) begin
      pos_r <= pos_r + 1'b1;
      if (pos_r == '1) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  // squares of the leaving and the arriving sample
  logic signed [SAMPLE_BITS-1:0] old_samp;
  logic signed [V_W-1:0]         sq_old_full, sq_new_full;
  logic [SQ_W-1:0]               sq_old_r, sq_new_r;

  assign old_samp    = wrapped_r ? rd_data_r : '0;
  assign sq_old_full = old_samp * old_samp;
  assign sq_new_full = samp_r * samp_r;

  always_ff @(posedge clk) begin
    if (cmd.ring_upd) begin
      sq_old_r <= sq_old_full[SQ_W-1:0];
      sq_new_r <= sq_new_full[SQ_W-1:0];
    end
  end

  // running sum and interval counter
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W:0]   count_inc;

  assign count_inc = {1'b0, count_r} + 1'b1;
  assign sts.hit   = count_inc >= {1'b0, interval_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (cmd.sum_upd) begin
      sum_r   <= sum_r - SUM_W'(sq_old_r) + SUM_W'(sq_new_r);
      count_r <= sts.hit ? '0 : count_inc[CNT_W-1:0];
    end
  end

  // restoring square root, one bit per step
  logic [V_W-1:0]         v_r;
  logic [REM_W-1:0]       rem_r;
  logic [SAMPLE_BITS-1:0] root_r;
  logic [IT_W-1:0]        it_r;
  logic [REM_W-1:0]       rem_sh, trial;
  logic                   ge;
  logic [SAMPLE_BITS-1:0] root_nxt;
  logic [ENV_W-1:0]       env_sat;

  assign rem_sh   = {rem_r[SAMPLE_BITS-1:0], v_r[V_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign ge       = rem_sh >= trial;
  assign root_nxt = {root_r[SAMPLE_BITS-2:0], ge};
  assign env_sat  = (root_nxt > SAMPLE_BITS'({ENV_W{1'b1}})) ? '1 : ENV_W'(root_nxt);
  assign sts.root_last = it_r == IT_W'(SAMPLE_BITS - 1);

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      v_r    <= {1'b0, sum_r[SUM_W-1:AW]};
      rem_r  <= '0;
      root_r <= '0;
      it_r   <= '0;
    end else if (cmd.root_step) begin
      v_r    <= {v_r[V_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= root_nxt;
      it_r   <= it_r + 1'b1;
    end
  end

  // stored features
  logic [LVL_W-1:0] snore_r, breath_r, signal_r, splash_r, band_r;
  logic [ENV_W-1:0] env_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snore_r  <= RST_SNORE;
      breath_r <= RST_BREATH;
      signal_r <= RST_SIGNAL;
      splash_r <= RST_SPLASH;
      band_r   <= RST_BAND;
      env_r    <= RST_ENVELOPE;
    end else if (cmd.accept && in_operation == OP_FEATURE) begin
      snore_r  <= in_snore_level;
      breath_r <= in_breath_level;
      signal_r <= in_signal_level;
      splash_r <= in_splash_level;
      band_r   <= in_band_level;
      env_r    <= in_envelope_level;
    end else if (cmd.root_step && sts.root_last) begin
      env_r <= env_sat;
    end
  end

  // scoring
  logic [LVL_W+1:0]   snore2, breath3;
  logic [SCORE_W-1:0] score, prob;
  logic               yes;

  assign snore2  = {1'b0, snore_r, 1'b0};
  assign breath3 = {1'b0, breath_r, 1'b0} + {2'b00, breath_r};

  always_comb begin
    score = '0;
    if (snore_r > thr_snore_r)   score = score + W_SNORE;
    if (signal_r > thr_signal_r) score = score + W_SIGNAL;
    if (splash_r > thr_splash_r) score = score + W_SPLASH;
    if (band_r > thr_band_r)     score = score + W_BAND;
    if (env_r > thr_env_r)       score = score + W_ENVELOPE;
    if (snore2 > breath3)        score = score + W_RATIO;
  end

  assign yes  = score > SNORE_MIN;
  assign prob = (score > SCORE_MAX) ? SCORE_MAX : score;

  // output register
  logic               out_valid_r;
  logic               snoring_r;
  logic [SCORE_W-1:0] prob_r, conf_r;
  logic [ENV_W-1:0]   out_env_r;

  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      snoring_r <= yes;
      prob_r    <= prob;
      conf_r    <= yes ? prob : SCORE_MAX - prob;
      out_env_r <= env_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_snoring           = snoring_r;
  assign out_snore_probability = prob_r;
  assign out_confidence        = conf_r;
  assign out_envelope          = out_env_r;

endmodule

### sv/audio_rms_snore_classifier_top.sv
// Snore classifier over an audio RMS envelope: top level.
//
// Audio samples go into a WINDOW_DEPTH-entry ring while a running sum of squares is
// kept; every update_interval samples the envelope floor(sqrt(sum / WINDOW_DEPTH)) is
// computed and a snore score is emitted. A feature request replaces all stored
// features and emits at once. One request is in work at a time: an audio sample that
// emits nothing goes through accept, ring write and squaring, and sum update; one that
// ends an interval adds root load, the root steps (one root bit per cycle) and emit;
// a feature request goes straight from accept to emit and skips the square root.
// A result waits in the output register while the next request is taken; a request
// that emits stalls only if that register is still full. The ring holds no reset:
// entries read as zero until the write position first wraps, so no clearing pass is
// needed after reset. Configuration writes are taken every cycle (cfg_ready is tied
// high); unknown indexes are ignored.
module audio_rms_snore_classifier_top import arsc_pkg::*; #(
  parameter int WINDOW_DEPTH = 8192,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic signed [SAMPLE_BITS-1:0] in_audio_sample,
  input  logic [LVL_W-1:0]              in_snore_level,
  input  logic [LVL_W-1:0]              in_breath_level,
  input  logic [LVL_W-1:0]              in_signal_level,
  input  logic [LVL_W-1:0]              in_splash_level,
  input  logic [LVL_W-1:0]              in_band_level,
  input  logic [LVL_W-1:0]              in_envelope_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_snoring,
  output logic [SCORE_W-1:0]            out_snore_probability,
  output logic [SCORE_W-1:0]            out_confidence,
  output logic [ENV_W-1:0]              out_envelope
);

  arsc_cmd_t cmd;
  arsc_sts_t sts;

  assign cfg_ready = 1'b1;

  arsc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd)
  );

  arsc_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_valid),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_operation          (in_operation),
    .in_audio_sample       (in_audio_sample),
    .in_snore_level        (in_snore_level),
    .in_breath_level       (in_breath_level),
    .in_signal_level       (in_signal_level),
    .in_splash_level       (in_splash_level),
    .in_band_level         (in_band_level),
    .in_envelope_level     (in_envelope_level),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_snoring           (out_snoring),
    .out_snore_probability (out_snore_probability),
    .out_confidence        (out_confidence),
    .out_envelope          (out_envelope)
  );

endmodule

### sv/arsc_checker.sv
// Port-level checks for the snore classifier, bound to the top level.
module arsc_checker import arsc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_snoring,
  input logic [SCORE_W-1:0] out_snore_probability,
  input logic [SCORE_W-1:0] out_confidence,
  input logic [ENV_W-1:0]   out_envelope
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_snoring)
      && $stable(out_snore_probability) && $stable(out_confidence)
      && $stable(out_envelope))
    else $error("stalled result changed");

  a_prob_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_snore_probability <= SCORE_MAX)
    else $error("probability above limit");

  a_class_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_snoring == (out_snore_probability > SNORE_MIN))
    else $error("class disagrees with score");

  a_conf_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_confidence ==
      (out_snoring ? out_snore_probability : SCORE_MAX - out_snore_probability))
    else $error("confidence disagrees with score");

endmodule

bind audio_rms_snore_classifier_top arsc_checker u_arsc_checker (.*);

### dv/audio_rms_snore_classifier_checker.sv
// Checker for the audio RMS snore classifier: request tracking, score prediction, result compare.
module audio_rms_snore_classifier_checker import arsc_pkg::*; #(
  parameter int WINDOW_DEPTH = 8192,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_operation,
  input  logic signed [SAMPLE_BITS-1:0] in_audio_sample,
  input  logic [LVL_W-1:0]              in_snore_level,
  input  logic [LVL_W-1:0]              in_breath_level,
  input  logic [LVL_W-1:0]              in_signal_level,
  input  logic [LVL_W-1:0]              in_splash_level,
  input  logic [LVL_W-1:0]              in_band_level,
  input  logic [LVL_W-1:0]              in_envelope_level,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_snoring,
  input  logic [SCORE_W-1:0]            out_snore_probability,
  input  logic [SCORE_W-1:0]            out_confidence,
  input  logic [ENV_W-1:0]              out_envelope,
  output int                            fail_count,
  output int                            open_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = 2 * SAMPLE_BITS + POS_W;

  typedef struct packed {
    logic               snoring;
    logic [SCORE_W-1:0] probability;
    logic [SCORE_W-1:0] confidence;
    logic [ENV_W-1:0]   envelope;
  } score_t;

  // register copies
  logic [CNT_W-1:0] interval_cfg;
  logic [LVL_W-1:0] snore_thr, signal_thr, splash_thr, band_thr, envelope_thr;

  // window and stored features
  logic signed [SAMPLE_BITS-1:0] window_ring [WINDOW_DEPTH];
  logic [POS_W-1:0] wr_pos;
  logic [SUM_W-1:0] energy_sum;
  int unsigned      samples_since_update;
  logic [LVL_W-1:0] snore_lvl, breath_lvl, signal_lvl, splash_lvl, band_lvl;
  logic [ENV_W-1:0] envelope_lvl;

  score_t expected_scores[$];

  function automatic logic [31:0] isqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [2*SAMPLE_BITS-1:0] square(input logic signed [SAMPLE_BITS-1:0] s);
    logic signed [2*SAMPLE_BITS-1:0] p;
    p = s * s;
    return p;
  endfunction

  function automatic score_t score_features();
    logic [SCORE_W:0] score;
    score_t r;
    score = '0;
    if (snore_lvl > snore_thr) score += W_SNORE;
    if (signal_lvl > signal_thr) score += W_SIGNAL;
    if (splash_lvl > splash_thr) score += W_SPLASH;
    if (band_lvl > band_thr) score += W_BAND;
    if (envelope_lvl > envelope_thr) score += W_ENVELOPE;
    if ((18'(snore_lvl) << 1) > 18'(breath_lvl) * 18'd3) score += W_RATIO;
    r.snoring     = score > SNORE_MIN;
    r.probability = (score > SCORE_MAX) ? SCORE_MAX : score[SCORE_W-1:0];
    r.confidence  = r.snoring ? r.probability : SCORE_MAX - r.probability;
    r.envelope    = envelope_lvl;
    return r;
  endfunction

  always @(posedge clk) begin
    logic [31:0] root;
    score_t      got;
    score_t      want;
    if (!rst_n) begin
      interval_cfg = RST_UPDATE_INTERVAL;
      snore_thr    = RST_SNORE_THRESHOLD;
      signal_thr   = RST_SIGNAL_THRESHOLD;
      splash_thr   = RST_SPLASH_THRESHOLD;
      band_thr     = RST_BAND_THRESHOLD;
      envelope_thr = RST_ENVELOPE_THRESHOLD;
      for (int i = 0; i < WINDOW_DEPTH; i++) window_ring[i] = '0;
      wr_pos               = '0;
      energy_sum           = '0;
      samples_since_update = 0;
      snore_lvl    = RST_SNORE;
      breath_lvl   = RST_BREATH;
      signal_lvl   = RST_SIGNAL;
      splash_lvl   = RST_SPLASH;
      band_lvl     = RST_BAND;
      envelope_lvl = RST_ENVELOPE;
      expected_scores.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UPDATE_INTERVAL:    interval_cfg = cfg_data[CNT_W-1:0];
          REG_SNORE_THRESHOLD:    snore_thr    = cfg_data;
          REG_SIGNAL_THRESHOLD:   signal_thr   = cfg_data;
          REG_SPLASH_THRESHOLD:   splash_thr   = cfg_data;
          REG_BAND_THRESHOLD:     band_thr     = cfg_data;
          REG_ENVELOPE_THRESHOLD: envelope_thr = cfg_data;
          default: ;
        endcase
      end

      // compare before pushing: a request never produces its result on the edge it is taken
      if (out_valid && out_ready) begin
        got = '{out_snoring, out_snore_probability, out_confidence, out_envelope};
        if (expected_scores.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%t: unexpected result snoring=%0d prob=%0d conf=%0d env=%0d",
                     $realtime, got.snoring, got.probability, got.confidence, got.envelope);
        end else begin
          want = expected_scores.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%t: result mismatch: expected snoring=%0d prob=%0d conf=%0d env=%0d,",
                        " got snoring=%0d prob=%0d conf=%0d env=%0d"}, $realtime,
                       want.snoring, want.probability, want.confidence, want.envelope,
                       got.snoring, got.probability, got.confidence, got.envelope);
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_operation == OP_FEATURE) begin
          snore_lvl    = in_snore_level;
          breath_lvl   = in_breath_level;
          signal_lvl   = in_signal_level;
          splash_lvl   = in_splash_level;
          band_lvl     = in_band_level;
          envelope_lvl = in_envelope_level;
          expected_scores.push_back(score_features());
        end else begin
          energy_sum = energy_sum - square(window_ring[wr_pos]) + square(in_audio_sample);
          window_ring[wr_pos] = in_audio_sample;
          wr_pos++;
          // an interval of zero acts as one
          if (samples_since_update + 1 >= interval_cfg) begin
            samples_since_update = 0;
            root = isqrt(64'(energy_sum >> POS_W));
            envelope_lvl = (root > 32'hFFFF) ? 16'hFFFF : root[ENV_W-1:0];
            expected_scores.push_back(score_features());
          end else begin
            samples_since_update++;
          end
        end
      end
    end
    open_results <= expected_scores.size();
  end

endmodule

### dv/audio_rms_snore_classifier_top_tb.sv
// Testbench top for the audio RMS snore classifier: clock, reset, stimulus and verdict.
module audio_rms_snore_classifier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arsc_pkg::*;

  localparam int WINDOW_DEPTH   = 8192;
  localparam int SAMPLE_BITS    = 16;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int BATCHES        = 14;
  localparam int BATCH_ITEMS    = 44;
  localparam int STREAM_SAMPLES = 80;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum {SET_RANDOM, SET_LOWEST, SET_HIGHEST} setting_t;

  typedef struct packed {
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample;
    logic [LVL_W-1:0]       snore;
    logic [LVL_W-1:0]       breath;
    logic [LVL_W-1:0]       signal;
    logic [LVL_W-1:0]       splash;
    logic [LVL_W-1:0]       band;
    logic [LVL_W-1:0]       env;
  } req_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_operation;
  logic signed [SAMPLE_BITS-1:0] in_audio_sample;
  logic [LVL_W-1:0]              in_snore_level;
  logic [LVL_W-1:0]              in_breath_level;
  logic [LVL_W-1:0]              in_signal_level;
  logic [LVL_W-1:0]              in_splash_level;
  logic [LVL_W-1:0]              in_band_level;
  logic [LVL_W-1:0]              in_envelope_level;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_snoring;
  logic [SCORE_W-1:0]            out_snore_probability;
  logic [SCORE_W-1:0]            out_confidence;
  logic [ENV_W-1:0]              out_envelope;
  int                            fail_count;
  int                            open_results;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;

  // shadow of the thresholds, used only to aim stimulus near them
  logic [LVL_W-1:0] cur_thr [REG_SNORE_THRESHOLD:REG_ENVELOPE_THRESHOLD];

  audio_rms_snore_classifier_top #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) dut (.*);

  audio_rms_snore_classifier_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("audio_rms_snore_classifier_top_tb: FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx >= REG_SNORE_THRESHOLD && idx <= REG_ENVELOPE_THRESHOLD) cur_thr[idx] = data;
  endtask

  task automatic apply_setting(input setting_t mode);
    logic [CNT_W-1:0] ivl;
    logic [LVL_W-1:0] thr;
    case (mode)
      SET_LOWEST:  ivl = 10'd1;
      SET_HIGHEST: ivl = 10'd1023;
      default: begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: ivl = CNT_W'($urandom_range(1, 8));
          5, 6:          ivl = CNT_W'($urandom_range(9, 40));
          7:             ivl = 10'd1;
          8:             ivl = 10'd0;
          default:       ivl = CNT_W'($urandom_range(41, 1023));
        endcase
      end
    endcase
    // upper data bits are outside the interval register and must be dropped
    write_reg(REG_UPDATE_INTERVAL, {6'($urandom), ivl});
    for (int r = REG_SNORE_THRESHOLD; r <= REG_ENVELOPE_THRESHOLD; r++) begin
      case (mode)
        SET_LOWEST:  thr = '0;
        SET_HIGHEST: thr = '1;
        default: begin
          case ($urandom_range(0, 9))
            0:             thr = '0;
            1:             thr = '1;
            2, 3, 4, 5, 6: thr = LVL_W'($urandom_range(0, 1000));
            default:       thr = LVL_W'($urandom);
          endcase
        end
      endcase
      write_reg(CFG_IDX_W'(r), thr);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LVL_W-1:0] near_level(input logic [LVL_W-1:0] thr);
    int lo;
    int hi;
    lo = int'(thr) / 2;
    hi = int'(thr) * 2 + 4;
    if (hi > 65535) hi = 65535;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return thr;
      3:       return (thr == '1) ? thr : thr + 1'b1;
      4, 5, 6: return LVL_W'($urandom_range(hi, lo));
      default: return LVL_W'($urandom);
    endcase
  endfunction

  function automatic req_t feature_of(input logic [LVL_W-1:0] s, b, g, p, n, e);
    req_t q;
    q.op     = OP_FEATURE;
    q.sample = SAMPLE_BITS'($urandom);
    q.snore  = s;
    q.breath = b;
    q.signal = g;
    q.splash = p;
    q.band   = n;
    q.env    = e;
    return q;
  endfunction

  function automatic req_t audio_of(input logic [SAMPLE_BITS-1:0] smp);
    req_t q;
    q = feature_of(LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom),
                   LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom));
    q.op     = OP_AUDIO;
    q.sample = smp;
    return q;
  endfunction

  function automatic req_t audio_req();
    logic [SAMPLE_BITS-1:0] smp;
    case ($urandom_range(0, 9))
      0:          smp = 16'h7FFF;
      1:          smp = 16'h8000;
      2:          smp = '0;
      3, 4, 5, 6: smp = 16'($urandom_range(0, 1000)) - 16'd500;
      default:    smp = SAMPLE_BITS'($urandom);
    endcase
    return audio_of(smp);
  endfunction

  function automatic req_t feature_req();
    logic [LVL_W-1:0] s;
    logic [LVL_W-1:0] b;
    int               ratio;
    s = near_level(cur_thr[REG_SNORE_THRESHOLD]);
    ratio = (int'(s) * 2) / 3;
    // breath around two thirds of snore exercises the ratio test edge
    case ($urandom_range(0, 4))
      0:       b = '0;
      1:       b = LVL_W'(ratio);
      2:       b = LVL_W'(ratio + 1);
      3:       b = (ratio > 0) ? LVL_W'(ratio - 1) : '0;
      default: b = LVL_W'($urandom);
    endcase
    return feature_of(s, b, near_level(cur_thr[REG_SIGNAL_THRESHOLD]),
                      near_level(cur_thr[REG_SPLASH_THRESHOLD]),
                      near_level(cur_thr[REG_BAND_THRESHOLD]),
                      near_level(cur_thr[REG_ENVELOPE_THRESHOLD]));
  endfunction

  task automatic send_req(input req_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= q.op;
    in_audio_sample   <= q.sample;
    in_snore_level    <= q.snore;
    in_breath_level   <= q.breath;
    in_signal_level   <= q.signal;
    in_splash_level   <= q.splash;
    in_band_level     <= q.band;
    in_envelope_level <= q.env;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending, wait for every outstanding result, then let in-flight samples finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_batch(input int n, input int feature_pct);
    for (int i = 0; i < n; i++)
      send_req(($urandom_range(0, 99) < feature_pct) ? feature_req() : audio_req());
    drain();
  endtask

  initial begin
    setting_t mode;
    rst_n             <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    in_operation      <= OP_AUDIO;
    in_audio_sample   <= '0;
    in_snore_level    <= '0;
    in_breath_level   <= '0;
    in_signal_level   <= '0;
    in_splash_level   <= '0;
    in_band_level     <= '0;
    in_envelope_level <= '0;
    cur_thr[REG_SNORE_THRESHOLD]    = RST_SNORE_THRESHOLD;
    cur_thr[REG_SIGNAL_THRESHOLD]   = RST_SIGNAL_THRESHOLD;
    cur_thr[REG_SPLASH_THRESHOLD]   = RST_SPLASH_THRESHOLD;
    cur_thr[REG_BAND_THRESHOLD]     = RST_BAND_THRESHOLD;
    cur_thr[REG_ENVELOPE_THRESHOLD] = RST_ENVELOPE_THRESHOLD;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset thresholds
    send_req(feature_of(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_req(feature_of('1, '1, '1, '1, '1, '1));
    send_req(feature_of('1, 16'd0, '1, '1, '1, '1));       // score clipped to ten
    send_req(feature_of(16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0)); // zero breath, score five
    send_req(feature_of(16'd151, 16'd100, 16'd51, 16'd0, 16'd0, 16'd0));
    send_req(feature_of(16'd150, 16'd100, 16'd50, 16'd50, 16'd100, 16'd100)); // all at threshold
    send_req(audio_of(16'h7FFF));
    send_req(audio_of(16'h8000));
    send_req(audio_of(16'h0000));
    send_req(audio_of(16'hFFFF));
    send_req(audio_of(16'h0001));
    drain();
    // interval zero: every sample emits, and the count is already past it
    write_reg(REG_UPDATE_INTERVAL, 16'd0);
    cfg_valid <= 1'b0;
    repeat (3) send_req(audio_req());
    drain();
    write_reg(REG_UPDATE_INTERVAL, 16'd6);
    cfg_valid <= 1'b0;
    repeat (4) send_req(audio_req());
    drain();
    // lowered below the count: next sample emits
    write_reg(REG_UPDATE_INTERVAL, 16'd2);
    cfg_valid <= 1'b0;
    repeat (2) send_req(audio_req());
    drain();
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    cfg_valid <= 1'b0;
    send_req(feature_of(16'd151, 16'd100, 16'd51, 16'd51, 16'd101, 16'd101));
    drain();

    for (int b = 0; b < BATCHES; b++) begin
      if (b < 5) begin
        send_idle_pct = 11;
        recv_idle_pct = 45;
      end else if (b < 10) begin
        send_idle_pct = 45;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mode = (b == 2 || b == 12) ? SET_LOWEST : (b == 8) ? SET_HIGHEST : SET_RANDOM;
      apply_setting(mode);
      // interval one with a long result stall backs the block up into its input
      if (b == 2) hold_requests++;
      run_batch(BATCH_ITEMS, $urandom_range(10, 50));
    end

    // plain audio run with a wider interval
    write_reg(REG_UPDATE_INTERVAL, CFG_DATA_W'($urandom_range(20, 40)));
    cfg_valid <= 1'b0;
    for (int i = 0; i < STREAM_SAMPLES; i++) send_req(audio_req());
    drain();

    if (fail_count == 0 && open_results == 0)
      $display("audio_rms_snore_classifier_top_tb: PASS");
    else
      $display("audio_rms_snore_classifier_top_tb: FAIL");
    $finish;
  end

endmodule

### files.f
sv/arsc_pkg.sv
sv/arsc_ctrl.sv
sv/arsc_dp.sv
sv/audio_rms_snore_classifier_top.sv
sv/arsc_checker.sv
dv/audio_rms_snore_classifier_checker.sv
dv/audio_rms_snore_classifier_top_tb.sv
